>>> rtl/mtnl_pkg.sv
// shared types, constants and bit-interleave helpers for the morton neighbor lister
`default_nettype none
package mtnl_pkg;

	localparam int ID_W    = 31;
	localparam int X_W     = 16;
	localparam int Y_W     = 15;
	localparam int LEVEL_W = 4;
	localparam int NBR_N   = 9;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index, taken from paddr above the byte offset
	localparam logic [0:0] REG_MESH_LEVEL = 1'b0;

	// one classified tile waiting for the back end
	typedef struct packed {
		logic [X_W-1:0]   x;
		logic [Y_W-1:0]   y;
		logic [NBR_N-1:0] mask;
	} nbr_entry_t;

	function automatic logic [X_W-1:0] gather_x(input logic [ID_W-1:0] id);
		logic [X_W-1:0] v;
		v = '0;
		for (int k = 0; k < X_W; k++) begin
			v[k] = id[2*k];
		end
		return v;
	endfunction

	function automatic logic [Y_W-1:0] gather_y(input logic [ID_W-1:0] id);
		logic [Y_W-1:0] v;
		v = '0;
		for (int k = 0; k < Y_W; k++) begin
			v[k] = id[2*k+1];
		end
		return v;
	endfunction

	function automatic logic [ID_W-1:0] weave(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		logic [ID_W-1:0] c;
		c = '0;
		for (int k = 0; k < X_W; k++) begin
			c[2*k] = x[k];
		end
		for (int k = 0; k < Y_W; k++) begin
			c[2*k+1] = y[k];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mtnl_front.sv
// front end: splits the tile id and marks which of the nine neighbors are in range
`default_nettype none
module mtnl_front import mtnl_pkg::*; (
	input  wire logic               accept,
	input  wire logic [ID_W-1:0]    tile_id,
	input  wire logic [LEVEL_W-1:0] mesh_level,
	output nbr_entry_t              entry,
	output logic                    push
);

	logic [X_W-1:0] x;
	logic [Y_W-1:0] y;
	logic [X_W:0]   x_ext;
	logic [X_W:0]   max_x;
	logic [Y_W:0]   y_ext;
	logic [Y_W:0]   max_y;
	logic [2:0]     x_ok;
	logic [2:0]     y_ok;
	logic [NBR_N-1:0] mask;

	always_comb begin
		x     = gather_x(tile_id);
		y     = gather_y(tile_id);
		x_ext = {1'b0, x};
		y_ext = {1'b0, y};
		max_x = (X_W+1)'(1) << ({1'b0, mesh_level} + 5'd1);
		max_y = (Y_W+1)'(1) << mesh_level;

		// index 0 is offset -1, 1 is 0, 2 is +1
		x_ok[0] = (x != '0) && ((x_ext - (X_W+1)'(1)) < max_x);
		x_ok[1] = x_ext < max_x;
		x_ok[2] = (x_ext + (X_W+1)'(1)) < max_x;
		y_ok[0] = (y != '0) && ((y_ext - (Y_W+1)'(1)) < max_y);
		y_ok[1] = y_ext < max_y;
		y_ok[2] = (y_ext + (Y_W+1)'(1)) < max_y;

		// x offset is the outer loop: bit 3*i+j
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mask[3*i+j] = x_ok[i] & y_ok[j];
			end
		end

		entry.x    = x;
		entry.y    = y;
		entry.mask = mask;
		// a tile with no neighbor in range produces nothing
		push       = accept && (mask != '0);
	end

endmodule
`default_nettype wire

>>> rtl/mtnl_queue.sv
// short queue between the front and back ends
`default_nettype none
module mtnl_queue import mtnl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire nbr_entry_t wr_entry,
	input  wire logic       pop,
	output nbr_entry_t      rd_entry,
	output logic            full,
	output logic            nonempty
);

	nbr_entry_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	assign rd_entry = slot_q[rd_ptr_q];
	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;

endmodule
`default_nettype wire

>>> rtl/mtnl_back.sv
// back end: walks the in-range neighbors of one tile, one word per cycle
`default_nettype none
module mtnl_back import mtnl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire nbr_entry_t q_entry,
	input  wire logic       q_nonempty,
	output logic            pop,
	output logic            result_valid,
	output logic [ID_W-1:0] neighbor_id,
	output logic            last_neighbor
);

	nbr_entry_t       cur_q;
	logic             cur_valid_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_last_q;

	logic [NBR_N-1:0] low;
	logic [NBR_N-1:0] rest;
	logic             dx_m, dx_p, dy_m, dy_p;
	logic [X_W-1:0]   nx;
	logic [Y_W-1:0]   ny;
	logic             finish;

	always_comb begin
		// lowest pending neighbor and what is left after it
		rest = cur_q.mask & (cur_q.mask - NBR_N'(1));
		low  = cur_q.mask & ~rest;
		dx_m = low[2:0] != '0;
		dx_p = low[8:6] != '0;
		dy_m = low[0] | low[3] | low[6];
		dy_p = low[2] | low[5] | low[8];
		nx   = cur_q.x - X_W'(dx_m) + X_W'(dx_p);
		ny   = cur_q.y - Y_W'(dy_m) + Y_W'(dy_p);
		finish = cur_valid_q && (rest == '0);
		pop  = q_nonempty && (!cur_valid_q || finish);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= cur_valid_q;
			out_last_q  <= finish;
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end else if (cur_valid_q) begin
			cur_q.mask <= rest;
		end
		if (cur_valid_q) begin
			out_id_q <= weave(nx, ny);
		end
	end

	assign result_valid  = out_valid_q;
	assign neighbor_id   = out_id_q;
	assign last_neighbor = out_last_q;

endmodule
`default_nettype wire

>>> rtl/morton_tile_neighbor_list_core.sv
// top level of the morton tile neighbor lister with its register port
// Usage:
//   Set mesh_level through the APB port (byte address 0) while the block is idle.
//   The grid then has 2^(level+1) columns and 2^level rows.
//   Issue a tile by raising start with tile_id; it is taken at a clock edge where
//   busy is low. busy is high only while the two-entry queue is full.
//   For each tile the block emits every in-range tile of the 3x3 block around it,
//   x offset outer, y offset inner, one word per cycle on neighbor_id with
//   result_valid high for that one cycle; last_neighbor marks the final word.
//   A tile with no neighbor in range emits nothing.
// Timing:
//   first word of a tile passes the queue, the walker register and the output
//   register when the back end is free; a tile holds the back end while it
//   walks its in-range neighbors (1 to 9); words of the next tile follow with no
//   gap if queued. The front end takes one tile per cycle until the queue fills.
// Reset: arst_n clears the queue, the walker and mesh_level (level 0).
// The receiver cannot stall: every word is shown for exactly one cycle.
`default_nettype none
module morton_tile_neighbor_list_core import mtnl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  wire logic               start,
	input  wire logic [ID_W-1:0]    tile_id,
	output logic                    busy,
	output logic                    result_valid,
	output logic [ID_W-1:0]         neighbor_id,
	output logic                    last_neighbor
);

	logic [LEVEL_W-1:0] mesh_level_q;
	logic               accept;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_nonempty;
	nbr_entry_t         front_entry;
	nbr_entry_t         q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_level_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_MESH_LEVEL) begin
			mesh_level_q <= pwdata[LEVEL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_MESH_LEVEL) begin
			prdata = PDATA_W'(mesh_level_q);
		end
	end

	assign pready = 1'b1;
	assign busy   = q_full;
	assign accept = start && !busy;

	mtnl_front u_front (
		.accept     (accept),
		.tile_id    (tile_id),
		.mesh_level (mesh_level_q),
		.entry      (front_entry),
		.push       (push)
	);

	mtnl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.rd_entry (q_entry),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	mtnl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_entry       (q_entry),
		.q_nonempty    (q_nonempty),
		.pop           (pop),
		.result_valid  (result_valid),
		.neighbor_id   (neighbor_id),
		.last_neighbor (last_neighbor)
	);

endmodule
`default_nettype wire

>>> rtl/mtnl_checker.sv
// port-level checks for the morton neighbor lister, bound to the top level
`default_nettype none
module mtnl_checker import mtnl_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            result_valid,
	input wire logic [ID_W-1:0] neighbor_id,
	input wire logic            last_neighbor
);

	// last marker only rides on a valid word
	a_last_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_neighbor |-> result_valid)
		else $error("last_neighbor without result_valid");

	// words of one tile come out on consecutive cycles
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_neighbor |=> result_valid)
		else $error("gap inside a tile's neighbor list");

	// consecutive words of one tile name distinct tiles
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) && !$past(last_neighbor)
		|-> neighbor_id != $past(neighbor_id))
		else $error("repeated neighbor within one tile");

	// the queue fills only by taking a tile
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a tile being taken");

endmodule

bind morton_tile_neighbor_list_core mtnl_checker u_mtnl_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for the morton tile neighbor lister: directed tiles, random tiles, level sweeps
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mtnl_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            is_last;
	} nbr_word_t;

	// own z-order interleave: x on even bits, y on odd bits
	function automatic logic [ID_W-1:0] zorder_code(input int x, input int y);
		logic [ID_W-1:0] c;
		c = '0;
		for (int k = 0; k < X_W; k++) begin
			c[2*k] = x[k];
		end
		for (int k = 0; k < Y_W; k++) begin
			c[2*k+1] = y[k];
		end
		return c;
	endfunction

	class word_board;
		nbr_word_t          due[$];
		logic [LEVEL_W-1:0] level;
		int                 errors;

		function new();
			level = '0;
			errors = 0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// expand one accepted tile into its in-range 3x3 neighbors
		function void note_tile(input logic [ID_W-1:0] tile);
			int cx, cy, nx, ny, max_x, max_y, lv, n;
			nbr_word_t w;
			cx = 0;
			cy = 0;
			n = 0;
			for (int k = 0; k < X_W; k++) begin
				cx[k] = tile[2*k];
			end
			for (int k = 0; k < Y_W; k++) begin
				cy[k] = tile[2*k+1];
			end
			lv = int'(level);
			max_y = 1 << lv;
			max_x = 1 << (lv + 1);
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					nx = cx + dx;
					ny = cy + dy;
					if (nx >= 0 && ny >= 0 && nx < max_x && ny < max_y) begin
						w.id = zorder_code(nx, ny);
						w.is_last = 1'b0;
						due.insert(due.size(), w);
						n++;
					end
				end
			end
			if (n > 0) begin
				due[due.size()-1].is_last = 1'b1;
			end
		endfunction

		function void check_word(input logic [ID_W-1:0] id, input logic is_last);
			nbr_word_t w;
			if (due.size() == 0) begin
				$display("%0t: unexpected word neighbor_id %h last_neighbor %b", $time, id, is_last);
				errors++;
				return;
			end
			w = due.pop_front();
			if (id !== w.id) begin
				$display("%0t: neighbor_id expected %h got %h", $time, w.id, id);
				errors++;
			end
			if (is_last !== w.is_last) begin
				$display("%0t: last_neighbor expected %b got %b", $time, w.is_last, is_last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start = 1'b0;
	logic [ID_W-1:0]    tile_id = '0;
	logic               busy;
	logic               result_valid;
	logic [ID_W-1:0]    neighbor_id;
	logic               last_neighbor;

	word_board sb = new();

	morton_tile_neighbor_list_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.tile_id(tile_id),
		.busy(busy),
		.result_valid(result_valid),
		.neighbor_id(neighbor_id),
		.last_neighbor(last_neighbor)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			sb.check_word(neighbor_id, last_neighbor);
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// wait until every expected word is out, then let the pipeline settle
	task wait_quiet();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task write_level(input logic [PDATA_W-1:0] value);
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MESH_LEVEL, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.level = value[LEVEL_W-1:0];
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		if (prdata !== PDATA_W'(sb.level)) begin
			$display("%0t: mesh_level readback expected %h got %h", $time,
				PDATA_W'(sb.level), prdata);
			sb.errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one tile, hold start until taken, then maybe idle
	task send_tile(input logic [ID_W-1:0] id, input int idle_pct, input bit end_burst);
		bit taken;
		start <= 1'b1;
		tile_id <= id;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sb.note_tile(id);
		if (end_burst) begin
			start <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	initial begin
		int lvl, mx, my, pct, x, y;
		logic [ID_W-1:0] id;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset level is 0: grid of two columns and one row
		send_tile('0, 0, 1'b0);
		send_tile(zorder_code(1, 0), 0, 1'b0);
		send_tile(zorder_code(0, 1), 0, 1'b0);
		send_tile({ID_W{1'b1}}, 0, 1'b1);
		wait_quiet();
		send_tile(zorder_code(1, 0), 0, 1'b1);

		// upper pwdata bits must be dropped
		write_level(32'hFFFF_FFF0);
		send_tile(zorder_code(2, 0), 0, 1'b1);

		write_level(32'h0000_000F);
		send_tile('0, 0, 1'b0);
		send_tile({ID_W{1'b1}}, 0, 1'b0);
		send_tile(zorder_code(16'hFFFF, 0), 0, 1'b0);
		send_tile(zorder_code(0, 15'h7FFF), 0, 1'b0);
		send_tile(zorder_code(1000, 500), 0, 1'b0);
		send_tile(zorder_code(65535, 12345), 0, 1'b1);

		// just outside the grid by one, and by two
		write_level(32'h0000_0003);
		send_tile(zorder_code(16, 3), 0, 1'b0);
		send_tile(zorder_code(15, 8), 0, 1'b0);
		send_tile(zorder_code(17, 2), 0, 1'b0);
		send_tile(zorder_code(16, 8), 0, 1'b0);
		send_tile(zorder_code(5, 4), 0, 1'b0);
		send_tile(zorder_code(0, 7), 0, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lvl = 0;
				1, 3: lvl = 15;
				4: lvl = 1;
				default: lvl = $urandom_range(2, 14);
			endcase
			pct = (ph < 2) ? 33 : (ph < 4) ? 57 : 0;
			write_level(($urandom() & 32'hFFFF_FFF0) | lvl);
			mx = 1 << (lvl + 1);
			my = 1 << lvl;
			for (int i = 0; i < 44; i++) begin
				case ($urandom_range(0, 99)) inside
					[0:69]: begin
						x = $urandom_range(0, mx - 1);
						y = $urandom_range(0, my - 1);
						id = zorder_code(x, y);
					end
					[70:84]: begin
						case ($urandom_range(0, 2))
							0: x = 0;
							1: x = mx - 1;
							default: x = mx;
						endcase
						case ($urandom_range(0, 2))
							0: y = 0;
							1: y = my - 1;
							default: y = my;
						endcase
						id = zorder_code(x, y);
					end
					default: id = ID_W'($urandom());
				endcase
				send_tile(id, pct, i == 43);
			end
		end

		for (int n = 0; n < 2000 && sb.pending() != 0; n++) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> morton_tile_neighbor_list_core.f
rtl/mtnl_pkg.sv
rtl/mtnl_front.sv
rtl/mtnl_queue.sv
rtl/mtnl_back.sv
rtl/morton_tile_neighbor_list_core.sv
rtl/mtnl_checker.sv
sim/tb_top.sv
